// ===== design/cdpa_pkg.sv =====
// shared types, constants and the sigmoid table builder for the dot product neuron
// no dependencies; every other design file but cdpa_ram imports this package

package cdpa_pkg;

   localparam int FRACTION_BITS  = 12;
   localparam int MAX_DOT_LENGTH = 4096;
   localparam int TABLE_DEPTH    = 1024;

   localparam int DATA_W   = 16;
   localparam int LEN_W    = 13;
   localparam int ACC_W    = 48;
   localparam int PROD_W   = 2 * DATA_W;
   localparam int TBL_W    = 16;
   localparam int TBL_AW   = $clog2(TABLE_DEPTH);

   // lookup position: POS_BITS fractional bits of (arg + 8), INTERP_BITS after scaling
   localparam int POS_BITS    = 20;
   localparam int INTERP_BITS = 24;
   localparam int V_W         = POS_BITS + 4;
   localparam int RW          = INTERP_BITS - TBL_AW;

   localparam int QDEPTH  = 4;
   localparam int QA_W    = $clog2(QDEPTH);
   localparam int QLVL_W  = $clog2(QDEPTH + 1);

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [1:0] {
      ACT_IDENTITY = 2'd0,
      ACT_LOGISTIC = 2'd1,
      ACT_RELU     = 2'd2,
      ACT_TANH     = 2'd3
   } act_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ACT_MODE   = 3'd0,
      CSR_BIAS_EN    = 3'd1,
      CSR_BIAS_INPUT = 3'd2,
      CSR_GAIN       = 3'd3,
      CSR_DOT_LEN    = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_MUL,
      B_ADDR,
      B_INTERP,
      B_FINAL
   } bstate_type;

   typedef struct packed {
      act_mode_type             act_mode;
      logic                     bias_en;
      logic signed [DATA_W-1:0] bias_input;
      logic signed [DATA_W-1:0] logistic_gain;
      logic [LEN_W-1:0]         dot_length;
   } cfg_type;

   typedef logic [TABLE_DEPTH-1:0][TBL_W-1:0] sig_table_type;

   // unsigned quotient by shift and subtract, used only while building the table
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // exp(-f) in q30 for 0 <= f <= 1.0, truncated taylor series
   function automatic logic [63:0] exp_neg_q30(input logic [63:0] f);
      logic [63:0] term;
      longint      sum;
      term = 64'd1 << 30;
      sum  = longint'(64'd1 << 30);
      for (int k = 1; k <= 16; k++) begin
         term = udiv64((term * f) >> 30, 64'(k));
         if ((k & 1) == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      return (sum < 0) ? 64'd0 : 64'(sum);
   endfunction

   // sigmoid samples over -8..+8, evaluated at elaboration
   function automatic sig_table_type build_sig_table();
      sig_table_type tbl;
      logic [63:0]   e1;
      logic [63:0]   e;
      logic [63:0]   a;
      logic [63:0]   n;
      logic [63:0]   frac;
      logic [63:0]   den;
      logic [63:0]   num;
      longint        x;
      e1 = exp_neg_q30(64'd1 << 30);
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         x = longint'((64'(i) << (FRACTION_BITS + 4)) >> TBL_AW)
             - (longint'(8) << FRACTION_BITS);
         a = (x < 0) ? 64'(-x) : 64'(x);
         n = a >> FRACTION_BITS;
         frac = a & ((64'd1 << FRACTION_BITS) - 64'd1);
         e = exp_neg_q30(frac << (30 - FRACTION_BITS));
         for (int j = 0; j < 9; j++) begin
            if (64'(j) < n) begin
               e = (e * e1) >> 30;
            end
         end
         den = (64'd1 << 30) + e;
         num = (x < 0) ? (e << FRACTION_BITS) : ((64'd1 << 30) << FRACTION_BITS);
         tbl[i] = TBL_W'(udiv64(num + (den >> 1), den));
      end
      return tbl;
   endfunction

   localparam sig_table_type SIG_TABLE = build_sig_table();

endpackage

// ===== design/cdpa_ram.sv =====
// generic single write, dual read ram with registered read data
// no dependencies

module cdpa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== design/cdpa_queue.sv =====
// short queue of finished dot products between the mac front and the activation back
// depends on cdpa_pkg

module cdpa_queue (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  logic signed [cdpa_pkg::ACC_W-1:0] push_data,
   input  logic                              pop,
   output logic signed [cdpa_pkg::ACC_W-1:0] head,
   output logic [cdpa_pkg::QLVL_W-1:0]       level
);

   import cdpa_pkg::*;

   logic signed [ACC_W-1:0] mem_ff [QDEPTH];
   logic [QA_W-1:0]         wr_ptr_ff;
   logic [QA_W-1:0]         wr_ptr_in;
   logic [QA_W-1:0]         rd_ptr_ff;
   logic [QA_W-1:0]         rd_ptr_in;
   logic [QLVL_W-1:0]       level_ff;
   logic [QLVL_W-1:0]       level_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QA_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QA_W'(1) : rd_ptr_ff;
      level_in  = level_ff + QLVL_W'(push) - QLVL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head  = mem_ff[rd_ptr_ff];
   assign level = level_ff;

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> level_ff != QLVL_W'(QDEPTH))
      else $error("queue pushed while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> level_ff != '0)
      else $error("queue popped while empty");
`endif

endmodule

// ===== design/cdpa_front.sv =====
// front part: accepts pixel/weight words, multiplies and accumulates,
// spots the last pair of a product and queues the finished sum; depends on cdpa_pkg

module cdpa_front (
   input  logic                               clock,
   input  logic                               reset,
   input  cdpa_pkg::cfg_type                  cfg,
   input  logic                               hold,
   input  logic [cdpa_pkg::QLVL_W-1:0]        q_level,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [cdpa_pkg::DATA_W-1:0] req_pixel_value,
   input  logic signed [cdpa_pkg::DATA_W-1:0] req_weight_value,
   input  logic signed [cdpa_pkg::DATA_W-1:0] req_bias_weight,
   output logic                               push,
   output logic signed [cdpa_pkg::ACC_W-1:0]  push_data
);

   import cdpa_pkg::*;

   logic                     accept;
   logic [LEN_W-1:0]         len;
   logic [LEN_W-1:0]         cnt_next;
   logic                     last;
   logic [QLVL_W:0]          reserved;
   logic signed [ACC_W-1:0]  sum;

   logic [LEN_W-1:0]         pair_cnt_ff;
   logic [LEN_W-1:0]         pair_cnt_in;
   logic                     s1_valid_ff;
   logic                     s1_valid_in;
   logic                     s1_last_ff;
   logic                     s1_last_in;
   logic signed [PROD_W-1:0] s1_prod_ff;
   logic signed [PROD_W-1:0] s1_prod_in;
   logic signed [PROD_W-1:0] s1_bias_ff;
   logic signed [PROD_W-1:0] s1_bias_in;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;

   always_comb begin
      // zero length acts as one, long lengths clip to the maximum
      if (cfg.dot_length == '0) begin
         len = LEN_W'(1);
      end else if (LEN_W'(MAX_DOT_LENGTH) != '0
                   && cfg.dot_length > LEN_W'(MAX_DOT_LENGTH)) begin
         len = LEN_W'(MAX_DOT_LENGTH);
      end else begin
         len = cfg.dot_length;
      end

      // a queue slot is held for every sum still in the multiply stage
      reserved  = (QLVL_W + 1)'(q_level) + (QLVL_W + 1)'(s1_last_ff);
      req_stall = hold || (reserved >= (QLVL_W + 1)'(QDEPTH));
      accept    = req_valid && !req_stall;

      cnt_next = pair_cnt_ff + LEN_W'(1);
      last     = (cnt_next >= len);

      pair_cnt_in = pair_cnt_ff;
      if (accept) begin
         pair_cnt_in = last ? '0 : cnt_next;
      end

      s1_valid_in = accept;
      s1_last_in  = accept && last;
      s1_prod_in  = req_pixel_value * req_weight_value;
      s1_bias_in  = '0;
      if (last && cfg.bias_en) begin
         s1_bias_in = req_bias_weight * $signed(cfg.bias_input);
      end

      sum = acc_ff + ACC_W'(s1_prod_ff) + ACC_W'(s1_bias_ff);

      acc_in = acc_ff;
      if (s1_valid_ff) begin
         acc_in = s1_last_ff ? '0 : sum;
      end

      push      = s1_valid_ff && s1_last_ff;
      push_data = sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_cnt_ff <= '0;
         s1_valid_ff <= 1'b0;
         s1_last_ff  <= 1'b0;
         acc_ff      <= '0;
      end else begin
         pair_cnt_ff <= pair_cnt_in;
         s1_valid_ff <= s1_valid_in;
         s1_last_ff  <= s1_last_in;
         acc_ff      <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_prod_ff <= s1_prod_in;
      s1_bias_ff <= s1_bias_in;
   end

endmodule

// ===== design/cdpa_back.sv =====
// back part: loads the sigmoid table after reset, then takes finished sums from the
// queue, applies the activation and holds the result word; depends on cdpa_pkg, cdpa_ram

module cdpa_back (
   input  logic                               clock,
   input  logic                               reset,
   input  cdpa_pkg::cfg_type                  cfg,
   input  logic [cdpa_pkg::QLVL_W-1:0]        q_level,
   input  logic signed [cdpa_pkg::ACC_W-1:0]  q_head,
   output logic                               q_pop,
   output logic                               fill_busy,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [cdpa_pkg::DATA_W-1:0] rsp_activated_value,
   output logic [cdpa_pkg::DATA_W-1:0]        rsp_result_index,
   output logic                               rsp_saturated
);

   import cdpa_pkg::*;

   localparam int Z_W     = DATA_W + ACC_W;
   localparam int ACT_W   = ACC_W + 1 - FRACTION_BITS;
   localparam int DP_W    = TBL_W + RW + 2;
   localparam int LK_W    = TBL_W + 2;
   localparam int ZF_LOG  = 3 * FRACTION_BITS;
   localparam int ZF_TANH = 2 * FRACTION_BITS;
   localparam int SHR_LOG  = (ZF_LOG >= POS_BITS) ? ZF_LOG - POS_BITS : 0;
   localparam int SHL_LOG  = (ZF_LOG < POS_BITS) ? POS_BITS - ZF_LOG : 0;
   localparam int SHR_TANH = (ZF_TANH >= POS_BITS) ? ZF_TANH - POS_BITS : 0;
   localparam int SHL_TANH = (ZF_TANH < POS_BITS) ? POS_BITS - ZF_TANH : 0;

   localparam logic signed [Z_W-1:0]   LIM_LOG  = Z_W'(64'd1 << (ZF_LOG + 3));
   localparam logic signed [Z_W-1:0]   LIM_TANH = Z_W'(64'd1 << (ZF_TANH + 3));
   localparam logic signed [ACC_W:0]   HALF_LSB = (ACC_W + 1)'(1 << (FRACTION_BITS - 1));
   localparam logic signed [DP_W-1:0]  HALF_RW  = DP_W'(1 << (RW - 1));
   localparam logic signed [ACT_W-1:0] ONE      = ACT_W'(1 << FRACTION_BITS);
   localparam logic signed [ACT_W-1:0] Q_MAX    = ACT_W'((1 << (DATA_W - 1)) - 1);
   localparam logic signed [ACT_W-1:0] Q_MIN    = -ACT_W'(1 << (DATA_W - 1));
   localparam logic [TBL_AW-1:0]       LAST_IDX = TBL_AW'(TABLE_DEPTH - 1);

   bstate_type              state_ff;
   bstate_type              state_in;
   logic                    fill_busy_ff;
   logic                    fill_busy_in;
   logic [TBL_AW-1:0]       fill_cnt_ff;
   logic [TBL_AW-1:0]       fill_cnt_in;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] acc_in;
   logic signed [Z_W-1:0]   z_ff;
   logic signed [Z_W-1:0]   z_in;
   logic signed [ACT_W-1:0] act_ff;
   logic signed [ACT_W-1:0] act_in;
   logic [RW-1:0]           r_ff;
   logic [RW-1:0]           r_in;
   logic signed [DP_W-1:0]  dprod_ff;
   logic signed [DP_W-1:0]  dprod_in;
   logic [TBL_W-1:0]        t0_ff;
   logic [TBL_W-1:0]        t0_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_value_ff;
   logic signed [DATA_W-1:0] rsp_value_in;
   logic [DATA_W-1:0]       rsp_index_ff;
   logic [DATA_W-1:0]       rsp_index_in;
   logic                    rsp_sat_ff;
   logic                    rsp_sat_in;
   logic [DATA_W-1:0]       out_cnt_ff;
   logic [DATA_W-1:0]       out_cnt_in;

   logic [TBL_AW-1:0]       rd_idx;
   logic [TBL_AW-1:0]       rd_idx_next;
   logic [TBL_W-1:0]        rd_data0;
   logic [TBL_W-1:0]        rd_data1;

   logic signed [ACC_W:0]   round_sum;
   logic [Z_W-1:0]          u_log;
   logic [Z_W-1:0]          u_tanh;
   logic [V_W-1:0]          v_pos;
   logic                    z_hi;
   logic                    z_lo;
   logic signed [TBL_W:0]   diff;
   logic signed [LK_W-1:0]  lookup;
   logic signed [ACT_W-1:0] fin_act;
   logic                    out_free;

   cdpa_ram #(
      .WIDTH (TBL_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock     (clock),
      .wr_en     (fill_busy_ff),
      .wr_addr   (fill_cnt_ff),
      .wr_data   (SIG_TABLE[fill_cnt_ff]),
      .rd_addr_a (rd_idx),
      .rd_addr_b (rd_idx_next),
      .rd_data_a (rd_data0),
      .rd_data_b (rd_data1)
   );

   always_comb begin
      state_in     = state_ff;
      fill_busy_in = fill_busy_ff;
      fill_cnt_in  = fill_cnt_ff;
      acc_in       = acc_ff;
      z_in         = z_ff;
      act_in       = act_ff;
      r_in         = r_ff;
      dprod_in     = dprod_ff;
      t0_in        = t0_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_index_in = rsp_index_ff;
      rsp_sat_in   = rsp_sat_ff;
      out_cnt_in   = out_cnt_ff;
      q_pop        = 1'b0;

      // table load sweep, one entry a cycle
      if (fill_busy_ff) begin
         fill_cnt_in = fill_cnt_ff + TBL_AW'(1);
         if (fill_cnt_ff == LAST_IDX) begin
            fill_busy_in = 1'b0;
         end
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      out_free = !rsp_valid_ff || !rsp_stall;

      // identity and relu, rounded half up
      round_sum = ((cfg.act_mode == ACT_RELU && acc_ff < 0) ? '0 : (ACC_W + 1)'(acc_ff))
                  + HALF_LSB;

      // table position of the activation argument
      u_log  = Z_W'(z_ff + LIM_LOG);
      u_tanh = Z_W'(z_ff + LIM_TANH);
      if (cfg.act_mode == ACT_LOGISTIC) begin
         z_hi  = (z_ff >= LIM_LOG);
         z_lo  = (z_ff < -LIM_LOG);
         v_pos = V_W'((u_log >> SHR_LOG) << SHL_LOG);
      end else begin
         z_hi  = (z_ff >= LIM_TANH);
         z_lo  = (z_ff < -LIM_TANH);
         v_pos = V_W'((u_tanh >> SHR_TANH) << SHL_TANH);
      end
      if (z_hi) begin
         rd_idx = LAST_IDX;
      end else if (z_lo) begin
         rd_idx = '0;
      end else begin
         rd_idx = TBL_AW'(v_pos >> RW);
      end
      rd_idx_next = (rd_idx == LAST_IDX) ? rd_idx : rd_idx + TBL_AW'(1);

      diff    = $signed({1'b0, rd_data1}) - $signed({1'b0, rd_data0});
      lookup  = $signed({2'b00, t0_ff}) + LK_W'((dprod_ff + HALF_RW) >>> RW);

      unique case (cfg.act_mode)
         ACT_LOGISTIC: fin_act = ACT_W'(lookup);
         ACT_TANH:     fin_act = (ACT_W'(lookup) <<< 1) - ONE;
         default:      fin_act = act_ff;
      endcase

      unique case (state_ff)
         B_IDLE: begin
            if (!fill_busy_ff && q_level != '0) begin
               q_pop    = 1'b1;
               acc_in   = q_head;
               state_in = B_MUL;
            end
         end
         B_MUL: begin
            if (cfg.act_mode == ACT_LOGISTIC) begin
               z_in = Z_W'($signed(cfg.logistic_gain)) * Z_W'(acc_ff);
            end else begin
               z_in = Z_W'(acc_ff) <<< 1;
            end
            act_in   = ACT_W'(round_sum >>> FRACTION_BITS);
            state_in = B_ADDR;
         end
         B_ADDR: begin
            r_in     = (z_hi || z_lo) ? '0 : v_pos[RW-1:0];
            state_in = B_INTERP;
         end
         B_INTERP: begin
            t0_in    = rd_data0;
            dprod_in = diff * $signed({1'b0, r_ff});
            state_in = B_FINAL;
         end
         B_FINAL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = out_cnt_ff;
               out_cnt_in   = out_cnt_ff + DATA_W'(1);
               if (fin_act > Q_MAX) begin
                  rsp_value_in = DATA_W'(Q_MAX);
                  rsp_sat_in   = 1'b1;
               end else if (fin_act < Q_MIN) begin
                  rsp_value_in = DATA_W'(Q_MIN);
                  rsp_sat_in   = 1'b1;
               end else begin
                  rsp_value_in = DATA_W'(fin_act);
                  rsp_sat_in   = 1'b0;
               end
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         fill_busy_ff <= 1'b1;
         fill_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         out_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         fill_busy_ff <= fill_busy_in;
         fill_cnt_ff  <= fill_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         out_cnt_ff   <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      z_ff         <= z_in;
      act_ff       <= act_in;
      r_ff         <= r_in;
      dprod_ff     <= dprod_in;
      t0_ff        <= t0_in;
      rsp_value_ff <= rsp_value_in;
      rsp_index_ff <= rsp_index_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign fill_busy           = fill_busy_ff;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_activated_value = rsp_value_ff;
   assign rsp_result_index    = rsp_index_ff;
   assign rsp_saturated       = rsp_sat_ff;

`ifndef SYNTHESIS
   a_idle_while_fill: assert property (@(posedge clock) disable iff (reset)
      fill_busy_ff |-> state_ff == B_IDLE)
      else $error("activation started before table load finished");

   a_count_on_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_FINAL && out_free) |=> out_cnt_ff == $past(out_cnt_ff) + DATA_W'(1))
      else $error("result index did not advance");
`endif

endmodule

// ===== design/conv_dot_product_activation.sv =====
// top level of the dot product neuron: config registers, mac front, queue, activation back
// depends on cdpa_pkg, cdpa_front, cdpa_queue, cdpa_back
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_stall   pixel_value, weight_value, bias_weight
//   rsp       out        rsp_valid/rsp_stall   activated_value, result_index, saturated
//   csr       in         csr_write_enable      csr_index, csr_write_data
//
// the front takes one word a cycle unless stalled; the product is registered, then summed
// the back handles one finished dot product at a time, in the steps pop, multiply,
// table address, interpolate, round and saturate; the last step waits on rsp_stall
// after reset the 1024 table ram entries are loaded, during which req_stall is high
// req_stall also rises when the four entry queue has no slot for a pending sum

module conv_dot_product_activation (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [cdpa_pkg::DATA_W-1:0]    req_pixel_value,
   input  logic signed [cdpa_pkg::DATA_W-1:0]    req_weight_value,
   input  logic signed [cdpa_pkg::DATA_W-1:0]    req_bias_weight,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [cdpa_pkg::DATA_W-1:0]    rsp_activated_value,
   output logic [cdpa_pkg::DATA_W-1:0]           rsp_result_index,
   output logic                                  rsp_saturated,
   input  logic                                  csr_write_enable,
   input  logic [cdpa_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [cdpa_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   import cdpa_pkg::*;

   act_mode_type             act_mode_ff;
   act_mode_type             act_mode_in;
   logic                     bias_en_ff;
   logic                     bias_en_in;
   logic signed [DATA_W-1:0] bias_input_ff;
   logic signed [DATA_W-1:0] bias_input_in;
   logic signed [DATA_W-1:0] gain_ff;
   logic signed [DATA_W-1:0] gain_in;
   logic [LEN_W-1:0]         dot_len_ff;
   logic [LEN_W-1:0]         dot_len_in;

   cfg_type                  cfg;
   logic                     fill_busy;
   logic [QLVL_W-1:0]        q_level;
   logic signed [ACC_W-1:0]  q_head;
   logic                     q_push;
   logic signed [ACC_W-1:0]  q_push_data;
   logic                     q_pop;

   always_comb begin
      act_mode_in   = act_mode_ff;
      bias_en_in    = bias_en_ff;
      bias_input_in = bias_input_ff;
      gain_in       = gain_ff;
      dot_len_in    = dot_len_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ACT_MODE:   act_mode_in   = act_mode_type'(csr_write_data[1:0]);
            CSR_BIAS_EN:    bias_en_in    = csr_write_data[0];
            CSR_BIAS_INPUT: bias_input_in = DATA_W'(csr_write_data);
            CSR_GAIN:       gain_in       = DATA_W'(csr_write_data);
            CSR_DOT_LEN:    dot_len_in    = csr_write_data[LEN_W-1:0];
            default: begin
               // unmapped index, nothing written
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_mode_ff   <= ACT_IDENTITY;
         bias_en_ff    <= 1'b0;
         bias_input_ff <= '0;
         gain_ff       <= DATA_W'(1 << FRACTION_BITS);
         dot_len_ff    <= LEN_W'(1);
      end else begin
         act_mode_ff   <= act_mode_in;
         bias_en_ff    <= bias_en_in;
         bias_input_ff <= bias_input_in;
         gain_ff       <= gain_in;
         dot_len_ff    <= dot_len_in;
      end
   end

   always_comb begin
      cfg.act_mode      = act_mode_ff;
      cfg.bias_en       = bias_en_ff;
      cfg.bias_input    = bias_input_ff;
      cfg.logistic_gain = gain_ff;
      cfg.dot_length    = dot_len_ff;
   end

   cdpa_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .hold             (fill_busy),
      .q_level          (q_level),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel_value  (req_pixel_value),
      .req_weight_value (req_weight_value),
      .req_bias_weight  (req_bias_weight),
      .push             (q_push),
      .push_data        (q_push_data)
   );

   cdpa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .head      (q_head),
      .level     (q_level)
   );

   cdpa_back u_back (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .q_level             (q_level),
      .q_head              (q_head),
      .q_pop               (q_pop),
      .fill_busy           (fill_busy),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_activated_value (rsp_activated_value),
      .rsp_result_index    (rsp_result_index),
      .rsp_saturated       (rsp_saturated)
   );

endmodule

// ===== tb/neuron_output_checker.sv =====
// checker for the dot product neuron: watches the word, result and register ports
// keeps its own accumulator, settings and sigmoid table, and compares each result
// depends on cdpa_pkg for widths, activation codes and register indexes

module neuron_output_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic signed [cdpa_pkg::DATA_W-1:0]   req_pixel_value,
   input  logic signed [cdpa_pkg::DATA_W-1:0]   req_weight_value,
   input  logic signed [cdpa_pkg::DATA_W-1:0]   req_bias_weight,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic signed [cdpa_pkg::DATA_W-1:0]   rsp_activated_value,
   input  logic [cdpa_pkg::DATA_W-1:0]          rsp_result_index,
   input  logic                                 rsp_saturated,
   input  logic                                 csr_write_enable,
   input  logic [cdpa_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [cdpa_pkg::CSR_DATA_W-1:0]      csr_write_data,
   output int                                   error_count,
   output int                                   outputs_due,
   output int                                   results_seen
);

   import cdpa_pkg::*;

   localparam int LUT_POS_FRAC    = 20;
   localparam int LUT_INTERP_FRAC = 24;
   localparam int PRINT_LIMIT     = 40;
   localparam longint HALF_LSB    = longint'(1) << (FRACTION_BITS - 1);

   typedef struct {
      logic signed [DATA_W-1:0] value;
      logic [DATA_W-1:0]        index;
      logic                     sat;
   } neuron_result_type;

   neuron_result_type        neuron_outputs_due[$];
   logic [15:0]              sig_lut [TABLE_DEPTH];

   act_mode_type             mode_q;
   logic                     bias_en_q;
   logic signed [DATA_W-1:0] bias_input_q;
   logic signed [DATA_W-1:0] gain_q;
   logic [LEN_W-1:0]         dot_len_q;
   longint                   acc_q;
   int unsigned              pairs_q;
   logic [DATA_W-1:0]        outputs_q;
   int                       mismatches;
   int                       taken;

   // exp(-f) in q30 for 0 <= f <= 1.0, truncated taylor series
   function automatic longint unsigned exp_neg_fixed(input longint unsigned f);
      longint unsigned term;
      longint          total;
      term  = 64'd1 << 30;
      total = longint'(64'd1 << 30);
      for (int k = 1; k <= 16; k++) begin
         term = ((term * f) >> 30) / 64'(k);
         if (k % 2 == 1) begin
            total = total - longint'(term);
         end else begin
            total = total + longint'(term);
         end
      end
      return (total < 0) ? 64'd0 : 64'(total);
   endfunction

   initial begin
      longint unsigned e_one, e, mag, whole, frac, den, num;
      longint          x;
      e_one = exp_neg_fixed(64'd1 << 30);
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         x = longint'((64'(i) << (FRACTION_BITS + 4)) / TABLE_DEPTH)
             - (longint'(8) << FRACTION_BITS);
         mag   = (x < 0) ? 64'(-x) : 64'(x);
         whole = mag >> FRACTION_BITS;
         frac  = mag & ((64'd1 << FRACTION_BITS) - 64'd1);
         e     = exp_neg_fixed(frac << (30 - FRACTION_BITS));
         while (whole > 0) begin
            e     = (e * e_one) >> 30;
            whole = whole - 64'd1;
         end
         den = (64'd1 << 30) + e;
         num = (x < 0) ? (e << FRACTION_BITS) : (64'd1 << (30 + FRACTION_BITS));
         sig_lut[i] = 16'((num + den / 64'd2) / den);
      end
   end

   // interpolated sigmoid of z, z carrying zfrac fraction bits
   function automatic longint sigmoid_interp(input longint z, input int unsigned zfrac);
      longint          lim;
      longint unsigned u, v, w, rem, t0, t1, slot;
      lim = longint'(8) << zfrac;
      if (z >= lim) return longint'(sig_lut[TABLE_DEPTH-1]);
      if (z < -lim) return longint'(sig_lut[0]);
      u = z + lim;
      if (zfrac >= LUT_POS_FRAC) begin
         v = u >> (zfrac - LUT_POS_FRAC);
      end else begin
         v = u << (LUT_POS_FRAC - zfrac);
      end
      w    = v * 64'(TABLE_DEPTH);
      slot = w >> LUT_INTERP_FRAC;
      if (slot >= TABLE_DEPTH) slot = TABLE_DEPTH - 1;
      rem = w & ((64'd1 << LUT_INTERP_FRAC) - 64'd1);
      t0  = sig_lut[slot];
      t1  = (slot + 1 < TABLE_DEPTH) ? sig_lut[slot + 1] : t0;
      return longint'((t0 * ((64'd1 << LUT_INTERP_FRAC) - rem) + t1 * rem
                       + (64'd1 << (LUT_INTERP_FRAC - 1))) >> LUT_INTERP_FRAC);
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) $display("%0t: mismatch: %s", $time, what);
   endtask

   task automatic apply_reg_write(input logic [CSR_IDX_W-1:0] idx,
                                  input logic [CSR_DATA_W-1:0] data);
      case (csr_index_type'(idx))
         CSR_ACT_MODE:   mode_q       = act_mode_type'(data[1:0]);
         CSR_BIAS_EN:    bias_en_q    = data[0];
         CSR_BIAS_INPUT: bias_input_q = data;
         CSR_GAIN:       gain_q       = data;
         CSR_DOT_LEN:    dot_len_q    = data[LEN_W-1:0];
         default: ;
      endcase
   endtask

   // one multiply-accumulate; on the closing word, the activated result is queued
   task automatic accumulate_pair(input logic signed [DATA_W-1:0] pix,
                                  input logic signed [DATA_W-1:0] wt,
                                  input logic signed [DATA_W-1:0] bw);
      int unsigned       span;
      longint            act;
      logic              sat;
      neuron_result_type r;
      span = (dot_len_q == 0) ? 1 :
             ((dot_len_q > MAX_DOT_LENGTH) ? MAX_DOT_LENGTH : dot_len_q);
      acc_q   = acc_q + longint'(pix) * longint'(wt);
      pairs_q = (pairs_q + 1) & 32'h1FFF;
      if (pairs_q < span) return;
      if (bias_en_q) acc_q = acc_q + longint'(bw) * longint'(bias_input_q);
      case (mode_q)
         ACT_LOGISTIC: act = sigmoid_interp(longint'(gain_q) * acc_q, 3 * FRACTION_BITS);
         ACT_TANH:     act = 2 * sigmoid_interp(2 * acc_q, 2 * FRACTION_BITS)
                             - (longint'(1) << FRACTION_BITS);
         ACT_RELU:     act = ((acc_q < 0 ? longint'(0) : acc_q) + HALF_LSB) >>> FRACTION_BITS;
         default:      act = (acc_q + HALF_LSB) >>> FRACTION_BITS;
      endcase
      sat = 1'b0;
      if (act > 32767) begin
         act = 32767;
         sat = 1'b1;
      end
      if (act < -32768) begin
         act = -32768;
         sat = 1'b1;
      end
      r.value = act[DATA_W-1:0];
      r.index = outputs_q;
      r.sat   = sat;
      neuron_outputs_due.push_back(r);
      outputs_q = outputs_q + 1'b1;
      acc_q     = 0;
      pairs_q   = 0;
   endtask

   task automatic compare_output();
      neuron_result_type want;
      if (neuron_outputs_due.size() == 0) begin
         report_mismatch($sformatf("unexpected word value %0d index %0d",
                                   rsp_activated_value, rsp_result_index));
         return;
      end
      want = neuron_outputs_due.pop_front();
      if (rsp_activated_value !== want.value)
         report_mismatch($sformatf("index %0d value %0d, predicted %0d",
                                   want.index, rsp_activated_value, want.value));
      if (rsp_result_index !== want.index)
         report_mismatch($sformatf("result index %0d, predicted %0d",
                                   rsp_result_index, want.index));
      if (rsp_saturated !== want.sat)
         report_mismatch($sformatf("index %0d clip flag %0b, predicted %0b",
                                   want.index, rsp_saturated, want.sat));
   endtask

   initial begin
      mismatches = 0;
      taken      = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         mode_q       = ACT_IDENTITY;
         bias_en_q    = 1'b0;
         bias_input_q = '0;
         gain_q       = 16'sd4096;
         dot_len_q    = 13'd1;
         acc_q        = 0;
         pairs_q      = 0;
         outputs_q    = '0;
         neuron_outputs_due.delete();
      end else begin
         if (csr_write_enable) apply_reg_write(csr_index, csr_write_data);
         if (req_valid && !req_stall)
            accumulate_pair(req_pixel_value, req_weight_value, req_bias_weight);
         if (rsp_valid && !rsp_stall) begin
            compare_output();
            taken++;
         end
      end
      error_count  <= mismatches;
      outputs_due  <= neuron_outputs_due.size();
      results_seen <= taken;
   end

endmodule

// ===== tb/tb_top.sv =====
// top of the dot product neuron testbench: clock, reset, word stimulus, stalls and verdict
// depends on cdpa_pkg, conv_dot_product_activation and neuron_output_checker

module tb_top;

   import cdpa_pkg::*;

   localparam int IDLE_LIMIT   = 5000;
   localparam int DRAIN_CYCLES = 32;
   localparam int RANDOM_WORDS = 740;
   localparam int PHASE_CAP    = 120;
   localparam int TAIL_WORDS   = 60;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic signed [DATA_W-1:0] req_pixel_value;
   logic signed [DATA_W-1:0] req_weight_value;
   logic signed [DATA_W-1:0] req_bias_weight;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [DATA_W-1:0] rsp_activated_value;
   logic [DATA_W-1:0]        rsp_result_index;
   logic                     rsp_saturated;
   logic                     csr_write_enable;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [CSR_DATA_W-1:0]    csr_write_data;

   int  err_count;
   int  due_count;
   int  results_seen;
   int  words_sent = 0;
   int  settings_count = 0;
   int  quiet_cycles = 0;
   bit  bursting = 1'b0;

   conv_dot_product_activation u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_pixel_value     (req_pixel_value),
      .req_weight_value    (req_weight_value),
      .req_bias_weight     (req_bias_weight),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_activated_value (rsp_activated_value),
      .rsp_result_index    (rsp_result_index),
      .rsp_saturated       (rsp_saturated),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   neuron_output_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_pixel_value     (req_pixel_value),
      .req_weight_value    (req_weight_value),
      .req_bias_weight     (req_bias_weight),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_activated_value (rsp_activated_value),
      .rsp_result_index    (rsp_result_index),
      .rsp_saturated       (rsp_saturated),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .error_count         (err_count),
      .outputs_due         (due_count),
      .results_seen        (results_seen)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   function automatic int pick_gap();
      return bursting ? 0 : $urandom_range(0, 6);
   endfunction

   // around +-1.0, keeps sums inside the q4.12 range most of the time
   function automatic logic [DATA_W-1:0] small_sample();
      return 16'($urandom_range(0, 8192) - 4096);
   endfunction

   function automatic logic [DATA_W-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0, 1: return 16'($urandom);
         2: begin
            case ($urandom_range(0, 3))
               0:       return 16'h8000;
               1:       return 16'h7fff;
               2:       return 16'h0000;
               default: return 16'hffff;
            endcase
         end
         default: return small_sample();
      endcase
   endfunction

   // result side: a fresh stall length is drawn for every word that shows up
   bit          rsp_taken = 1'b0;
   bit          hold_pending = 1'b1;
   int unsigned hold_left = 0;

   always @(posedge clock) rsp_taken <= rsp_valid && !rsp_stall;

   always @(negedge clock) begin
      if (rsp_taken) hold_pending = 1'b1;
      if (rsp_valid && hold_pending) begin
         hold_left    = pick_gap();
         hold_pending = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   task automatic push_word(input logic [DATA_W-1:0] pix, input logic [DATA_W-1:0] wt,
                            input logic [DATA_W-1:0] bw);
      int gap;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_pixel_value  <= pix;
      req_weight_value <= wt;
      req_bias_weight  <= bw;
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   // idle the input, let every predicted result arrive, then let the back stage drain
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic apply_settings(input act_mode_type mode, input bit ben,
                                 input logic [DATA_W-1:0] bval,
                                 input logic [DATA_W-1:0] gain,
                                 input logic [LEN_W-1:0] len);
      settle();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_ACT_MODE;
      csr_write_data   <= 16'(mode);
      @(negedge clock);
      csr_index        <= CSR_BIAS_EN;
      csr_write_data   <= 16'(ben);
      @(negedge clock);
      csr_index        <= CSR_BIAS_INPUT;
      csr_write_data   <= bval;
      @(negedge clock);
      csr_index        <= CSR_GAIN;
      csr_write_data   <= gain;
      @(negedge clock);
      csr_index        <= CSR_DOT_LEN;
      csr_write_data   <= 16'(len);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      settings_count++;
   endtask

   initial begin
      int unsigned len;
      int unsigned count;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_pixel_value  = '0;
      req_weight_value = '0;
      req_bias_weight  = '0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_ACT_MODE;
      csr_write_data   = '0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // reset settings: identity, one pair per product; extremes clip both ways
      push_word(16'h7fff, 16'h7fff, 16'h0000);
      push_word(16'h8000, 16'h8000, 16'h7fff);
      push_word(16'h8000, 16'h7fff, 16'h8000);
      push_word(16'h0000, 16'h0000, 16'h0000);
      push_word(16'hffff, 16'h0001, 16'hffff);
      push_word(16'h1000, 16'hf800, 16'h0000);

      // relu with bias, zero length acts as one
      apply_settings(ACT_RELU, 1'b1, 16'h8000, 16'h1000, 13'd0);
      push_word(16'h1000, 16'h1000, 16'h7fff);
      push_word(16'h8000, 16'h7fff, 16'h8000);
      push_word(16'h0800, 16'h0800, 16'h0000);

      // logistic, steepest gains; bias weight on the early words must be ignored
      apply_settings(ACT_LOGISTIC, 1'b1, 16'h7fff, 16'h7fff, 13'd3);
      push_word(16'h0400, 16'h0800, 16'h7fff);
      push_word(16'hfc00, 16'h0200, 16'h8000);
      push_word(16'h012c, 16'hfe70, 16'h1000);
      apply_settings(ACT_LOGISTIC, 1'b0, 16'h0000, 16'h8000, 13'd1);
      push_word(16'h0800, 16'h0800, 16'h0000);
      push_word(16'hf000, 16'h1000, 16'h0000);

      // tanh; length lowered and bias changed while a product is half done
      apply_settings(ACT_TANH, 1'b0, 16'h0000, 16'h1000, 13'd4);
      push_word(16'h1000, 16'h0400, 16'h0000);
      push_word(16'h0800, 16'h0800, 16'h0000);
      apply_settings(ACT_TANH, 1'b1, 16'h0800, 16'h1000, 13'd2);
      push_word(16'h0400, 16'h0400, 16'h1000);
      push_word(16'h7fff, 16'h7fff, 16'h0000);
      push_word(16'h8000, 16'h7fff, 16'h0000);
      apply_settings(ACT_TANH, 1'b0, 16'h0000, 16'h1000, 13'd1);
      push_word(16'h0000, 16'h0000, 16'h0000);
      push_word(16'h8000, 16'h8000, 16'h0000);
      push_word(16'h8000, 16'h7fff, 16'h0000);

      // random settings, mostly short products, phases may stop mid-product
      while (words_sent < RANDOM_WORDS + 22) begin
         if ($urandom_range(0, 9) == 0) begin
            len = 0;
         end else if ($urandom_range(0, 9) == 0) begin
            len = $urandom_range(9, 64);
         end else begin
            len = $urandom_range(1, 8);
         end
         apply_settings(act_mode_type'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                        pick_sample(), ($urandom_range(0, 1) == 1) ? small_sample()
                                                               : pick_sample(),
                        13'(len));
         bursting = ($urandom_range(0, 3) == 0);
         count = ((len == 0) ? 1 : len) * $urandom_range(1, 6);
         if ($urandom_range(0, 2) == 0) count = count + $urandom_range(0, len);
         if (count > PHASE_CAP) count = PHASE_CAP;
         repeat (count) push_word(pick_sample(), pick_sample(), pick_sample());
      end

      // the maximum length and one far above it (8191) keep the product open,
      // then a length of one closes it with everything gathered so far
      apply_settings(ACT_RELU, 1'b1, pick_sample(), 16'h1000, 13'd4096);
      bursting = 1'b0;
      repeat (TAIL_WORDS) push_word(small_sample(), small_sample(), pick_sample());
      apply_settings(ACT_IDENTITY, 1'b0, 16'h0000, 16'h1000, 13'd8191);
      bursting = 1'b1;
      repeat (TAIL_WORDS) push_word(small_sample(), small_sample(), pick_sample());
      apply_settings(ACT_IDENTITY, 1'b1, pick_sample(), 16'h1000, 13'd1);
      bursting = 1'b0;
      push_word(small_sample(), small_sample(), pick_sample());

      settle();
      $display("covered %0d input words and %0d results over %0d register settings",
               words_sent, results_seen, settings_count);
      $display("all four activations, zero and over-maximum lengths, mid-product changes");
      if (err_count == 0 && due_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
